### rtl/sopt_pkg.sv
// shared types and constants for the shape outline pixel test
`timescale 1ns / 1ps
package sopt_pkg;

  typedef enum logic [1:0] {
    SHAPE_CIRCLE = 2'd0,
    SHAPE_TRI    = 2'd1,
    SHAPE_RECT   = 2'd2,
    SHAPE_LINE   = 2'd3
  } shape_e;

  localparam logic [2:0] REG_KIND  = 3'd0;
  localparam logic [2:0] REG_POS_X = 3'd1;
  localparam logic [2:0] REG_POS_Y = 3'd2;
  localparam logic [2:0] REG_END_X = 3'd3;
  localparam logic [2:0] REG_END_Y = 3'd4;
  localparam logic [2:0] REG_EXT_A = 3'd5;
  localparam logic [2:0] REG_EXT_B = 3'd6;

  localparam int CoordW = 11;
  localparam int ExtW   = 10;
  localparam int PixW   = 6;
  // differences of an 11 bit coordinate and a pixel index
  localparam int DiffW  = 13;

endpackage

### rtl/shape_outline_pixel_test_unit.sv
// top level of the shape outline pixel test
`timescale 1ns / 1ps
// Shape outline hit test for one board cell per word.
// s_axis carries a cell (row, column); m_axis returns one word with the hit
// flag for each cell, in order. cfg_* writes the shape registers (index 0 kind,
// 1 pos_x, 2 pos_y, 3 end_x, 4 end_y, 5 extent_a, 6 extent_b); write only
// while no cell is in flight. Writes beyond index 6 are ignored.
// The path is four register stages: differences, squares and line products,
// the line quotient check and compares, and the output register. The first
// stage loads at the accepting edge; m_axis_tvalid is the fourth stage valid.
// One cell is accepted every cycle unless the receiver stalls. The line check
// compares dy*(c-x1) against (r-y1)*dx bounds instead of dividing, so no stage
// holds more than one multiplier level.
// When the receiver stalls the whole pipeline holds; s_axis_tready falls only
// when the output word is still waiting and every stage is full.
// Reset clears the shape registers to zero and empties the pipeline.
module shape_outline_pixel_test_unit
  import sopt_pkg::*;
#(
  parameter int BOARD_ROWS = 64,
  parameter int BOARD_COLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [5:0] pixel_row, [11:6] pixel_col
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] hit
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [1:0]               kind_q;
  logic signed [CoordW-1:0] pos_x_q, pos_y_q, end_x_q, end_y_q;
  logic [ExtW-1:0]          ext_a_q, ext_b_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= '0;
      pos_x_q <= '0;
      pos_y_q <= '0;
      end_x_q <= '0;
      end_y_q <= '0;
      ext_a_q <= '0;
      ext_b_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_KIND:  kind_q  <= cfg_data_i[1:0];
        REG_POS_X: pos_x_q <= cfg_data_i[CoordW-1:0];
        REG_POS_Y: pos_y_q <= cfg_data_i[CoordW-1:0];
        REG_END_X: end_x_q <= cfg_data_i[CoordW-1:0];
        REG_END_Y: end_y_q <= cfg_data_i[CoordW-1:0];
        REG_EXT_A: ext_a_q <= cfg_data_i[ExtW-1:0];
        REG_EXT_B: ext_b_q <= cfg_data_i[ExtW-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and advance enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  assign en4 = !v4_q || m_axis_tready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: differences against the anchors
  logic [PixW-1:0] row_in, col_in;
  assign row_in = s_axis_tdata[PixW-1:0];
  assign col_in = s_axis_tdata[2*PixW-1:PixW];

  logic signed [DiffW-1:0] r_s, c_s;
  assign r_s = DiffW'(signed'({1'b0, row_in}));
  assign c_s = DiffW'(signed'({1'b0, col_in}));

  logic signed [DiffW-1:0] dxr_q, dyc_q, cpx_q, rpy_q, ldx_q, ldy_q;
  logic                    onb1_q;
  logic [1:0]              kind1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      dxr_q   <= r_s - DiffW'(pos_x_q);
      dyc_q   <= c_s - DiffW'(pos_y_q);
      cpx_q   <= c_s - DiffW'(pos_x_q);
      rpy_q   <= r_s - DiffW'(pos_y_q);
      ldx_q   <= DiffW'(end_x_q) - DiffW'(pos_x_q);
      ldy_q   <= DiffW'(end_y_q) - DiffW'(pos_y_q);
      onb1_q  <= (32'(row_in) < BOARD_ROWS) && (32'(col_in) < BOARD_COLS);
      kind1_q <= kind_q;
    end
  end

  // stage 2: squares and line products
  logic signed [2*DiffW-1:0] sqr_q, sqc_q, num_q, rdx_q;
  logic signed [DiffW-1:0]   cpx2_q, rpy2_q, ldx2_q, ldy2_q;
  logic                      onb2_q;
  logic [1:0]                kind2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sqr_q   <= dxr_q * dxr_q;
      sqc_q   <= dyc_q * dyc_q;
      num_q   <= ldy_q * cpx_q;
      rdx_q   <= rpy_q * ldx_q;
      cpx2_q  <= cpx_q;
      rpy2_q  <= rpy_q;
      ldx2_q  <= ldx_q;
      ldy2_q  <= ldy_q;
      onb2_q  <= onb1_q;
      kind2_q <= kind1_q;
    end
  end

  // stage 3: compares per shape
  localparam int WW = 2 * DiffW + 2;
  logic signed [WW-1:0] dsq, rad, radm, rsq, rmsq;
  logic signed [WW-1:0] q, adx, num;
  logic signed [DiffW-1:0] h_s, w_s, negc;
  logic                 hit_c, hit_t, hit_r, hit_l, in_span, vert_ok, q_ok;
  logic                 hit3_q;

  always_comb begin
    dsq  = WW'(sqr_q) + WW'(sqc_q);
    rad  = WW'(signed'({1'b0, ext_a_q}));
    radm = rad - WW'(1);
    rsq  = rad * rad;
    rmsq = radm * radm;
    hit_c = (ext_a_q != '0) && (dsq <= rsq) && (dsq >= rmsq);

    h_s  = DiffW'(signed'({1'b0, ext_b_q}));
    w_s  = DiffW'(signed'({1'b0, ext_a_q}));
    negc = -cpx2_q;
    hit_t = (ext_b_q != '0) &&
            (((rpy2_q >= 0) && (rpy2_q < h_s) &&
              ((cpx2_q == -rpy2_q) || (cpx2_q == rpy2_q))) ||
             ((rpy2_q == h_s - DiffW'(1)) &&
              (cpx2_q <= h_s - DiffW'(1)) && (negc <= h_s - DiffW'(1))));

    hit_r = (rpy2_q >= 0) && (rpy2_q < h_s) && (cpx2_q >= 0) && (cpx2_q < w_s) &&
            ((rpy2_q == 0) || (rpy2_q == h_s - DiffW'(1)) ||
             (cpx2_q == 0) || (cpx2_q == w_s - DiffW'(1)));

    // column between endpoints: c-x1 between 0 and dx
    in_span = (ldx2_q >= 0) ? ((cpx2_q >= 0) && (cpx2_q <= ldx2_q))
                            : ((cpx2_q <= 0) && (cpx2_q >= ldx2_q));
    vert_ok = (cpx2_q == 0) &&
              ((ldy2_q >= 0) ? ((rpy2_q >= 0) && (rpy2_q <= ldy2_q))
                             : ((rpy2_q <= 0) && (rpy2_q >= ldy2_q)));
    // truncated quotient equals k=r-y1 iff num-k*dx lies in (-|dx|,|dx|)
    // and has the sign of num (or is zero)
    num = WW'(num_q);
    q   = num - WW'(rdx_q);
    adx = (ldx2_q < 0) ? -WW'(ldx2_q) : WW'(ldx2_q);
    q_ok = (q > -adx) && (q < adx) &&
           ((q == 0) || ((num >= 0) ? (q > 0) : (q < 0)));
    hit_l = (ldx2_q == 0) ? vert_ok : (in_span && q_ok);
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      case (shape_e'(kind2_q))
        SHAPE_CIRCLE: hit3_q <= onb2_q && hit_c;
        SHAPE_TRI:    hit3_q <= onb2_q && hit_t;
        SHAPE_RECT:   hit3_q <= onb2_q && hit_r;
        default:      hit3_q <= onb2_q && hit_l;
      endcase
    end
  end

  // stage 4: output register
  logic hit4_q;
  always_ff @(posedge clk_i) begin
    if (en4) hit4_q <= hit3_q;
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {7'd0, hit4_q};

endmodule

### tb/tb_top.sv
// testbench for the shape outline pixel test unit
`timescale 1ns / 1ps
module tb_top;
  import sopt_pkg::*;

  localparam int Rows = 64;
  localparam int Cols = 64;
  localparam int CycleLimit = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  shape_outline_pixel_test_unit #(.BOARD_ROWS(Rows), .BOARD_COLS(Cols)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // shadow of the shape registers
  shape_e          kind_q;
  logic [10:0]     px_q, py_q, ex_q, ey_q;
  logic [9:0]      ea_q, eb_q;

  logic [11:0] cell_q[$];   // pending cells: [5:0] row, [11:6] col
  logic        hit_q[$];    // expected hit flags
  int          errors;
  int          cycles;
  int          n_cells, n_hits, n_words;
  bit          out_hold;    // long receiver hold-off

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit outline_hit(int r, int c);
    longint x1, y1, x2, y2, dx, dy, lo, hi, d, rad, i, h, w, j, off;
    x1 = longint'($signed(px_q));
    y1 = longint'($signed(py_q));
    x2 = longint'($signed(ex_q));
    y2 = longint'($signed(ey_q));
    if (r >= Rows || c >= Cols) return 0;
    case (kind_q)
      SHAPE_CIRCLE: begin
        rad = ea_q;
        d = (r - x1) * (r - x1) + (c - y1) * (c - y1);
        return d <= rad * rad && d >= (rad - 1) * (rad - 1);
      end
      SHAPE_TRI: begin
        h = eb_q;
        i = r - y1;
        if (h == 0) return 0;
        if (i >= 0 && i < h && (c == x1 - i || c == x1 + i)) return 1;
        off = c - x1;
        if (off < 0) off = -off;
        return r == y1 + h - 1 && off <= h - 1;
      end
      SHAPE_RECT: begin
        j = c - x1;
        i = r - y1;
        w = ea_q;
        h = eb_q;
        if (i < 0 || i >= h || j < 0 || j >= w) return 0;
        return i == 0 || i == h - 1 || j == 0 || j == w - 1;
      end
      default: begin
        dx = x2 - x1;
        dy = y2 - y1;
        if (dx == 0) begin
          lo = (y1 < y2) ? y1 : y2;
          hi = (y1 < y2) ? y2 : y1;
          return c == x1 && r >= lo && r <= hi;
        end
        lo = (x1 < x2) ? x1 : x2;
        hi = (x1 < x2) ? x2 : x1;
        if (c < lo || c > hi) return 0;
        // systemverilog integer division truncates toward zero
        return r == y1 + (dy * (c - x1)) / dx;
      end
    endcase
  endfunction

  task automatic report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_KIND:  kind_q = shape_e'(val[1:0]);
      REG_POS_X: px_q = val[10:0];
      REG_POS_Y: py_q = val[10:0];
      REG_END_X: ex_q = val[10:0];
      REG_END_Y: ey_q = val[10:0];
      REG_EXT_A: ea_q = val[9:0];
      REG_EXT_B: eb_q = val[9:0];
      default: ;
    endcase
  endtask

  task automatic set_shape(shape_e k, int x, int y, int x2, int y2, int a, int b);
    write_reg(REG_KIND, 16'(k));
    write_reg(REG_POS_X, 16'(x));
    write_reg(REG_POS_Y, 16'(y));
    write_reg(REG_END_X, 16'(x2));
    write_reg(REG_END_Y, 16'(y2));
    write_reg(REG_EXT_A, 16'(a));
    write_reg(REG_EXT_B, 16'(b));
  endtask

  // wait until the pipeline is empty, then let the stages settle
  task automatic drain();
    wait (cell_q.size() == 0 && hit_q.size() == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_cell(int r, int c);
    cell_q.push_back({6'(c), 6'(r)});
  endtask

  function automatic int near_coord();
    // mostly on or near the board, sometimes anywhere
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2047) - 1024;
    return $urandom_range(0, 90) - 20;
  endfunction

  function automatic int small_ext();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, 40);
  endfunction

  task automatic random_cells(int n);
    for (int k = 0; k < n; k++) push_cell($urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  // driver
  int gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      gap <= 0;
    end else begin
      // the offered word stays at the front of the queue until accepted
      if (s_axis_tvalid && s_axis_tready) begin
        hit_q.push_back(outline_hit(s_axis_tdata[5:0], s_axis_tdata[11:6]));
        void'(cell_q.pop_front());
        n_cells++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the current word
      end else if (gap > 0) begin
        gap <= gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (cell_q.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, cell_q[0]};
        if ($urandom_range(0, 3) == 0)
          gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  int stall;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_words++;
        if (hit_q.size() == 0) report("result word with no cell pending");
        else begin
          if (m_axis_tdata[0] !== hit_q[0])
            report($sformatf("hit got %b expected %b", m_axis_tdata[0], hit_q[0]));
          if (m_axis_tdata[7:1] !== '0)
            report($sformatf("padding bits not zero: %h", m_axis_tdata));
          if (hit_q[0]) n_hits++;
          void'(hit_q.pop_front());
        end
      end
      if (out_hold) m_axis_tready <= 1'b0;
      else if (stall > 0) begin
        stall <= stall - 1;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int x, y, ax, ay;
    errors = 0; cycles = 0; n_cells = 0; n_hits = 0; n_words = 0;
    out_hold = 0;
    cfg_valid_i = 0; cfg_index_i = '0; cfg_data_i = '0;
    kind_q = SHAPE_CIRCLE;
    px_q = '0; py_q = '0; ex_q = '0; ey_q = '0; ea_q = '0; eb_q = '0;
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;

    // reset values: zero radius circle draws nothing
    push_cell(0, 0); push_cell(63, 63);
    drain();
    // circle partly off board, corner cells
    set_shape(SHAPE_CIRCLE, 5, 60, 0, 0, 8, 0);
    push_cell(0, 63); push_cell(13, 60); push_cell(5, 52); push_cell(63, 0);
    drain();
    // radius one ring includes the center
    write_reg(REG_EXT_A, 16'd1);
    push_cell(5, 60); push_cell(6, 60); push_cell(7, 60);
    drain();
    set_shape(SHAPE_TRI, 30, 10, 0, 0, 0, 6);
    push_cell(10, 30); push_cell(12, 28); push_cell(15, 35); push_cell(15, 25);
    push_cell(15, 24); push_cell(14, 30);
    drain();
    write_reg(REG_EXT_B, 16'd0);  // zero height triangle
    push_cell(10, 30);
    drain();
    set_shape(SHAPE_RECT, -3, 60, 0, 0, 10, 10);
    push_cell(60, 0); push_cell(63, 6); push_cell(61, 3);
    drain();
    write_reg(REG_EXT_A, 16'd0);  // zero width rectangle
    push_cell(60, 0);
    drain();
    // vertical line and negative slope line
    set_shape(SHAPE_LINE, 7, 40, 7, 20, 0, 0);
    push_cell(20, 7); push_cell(40, 7); push_cell(41, 7);
    drain();
    set_shape(SHAPE_LINE, 0, 10, 7, 0, 0, 0);
    push_cell(9, 1); push_cell(8, 1); push_cell(0, 7);
    drain();
    // extremes of every register
    set_shape(SHAPE_LINE, -1024, 1023, 1023, -1024, 1023, 1023);
    push_cell(63, 63); push_cell(0, 0); push_cell(32, 31);
    drain();

    // long receiver hold-off while cells keep coming
    out_hold = 1;
    random_cells(30);
    repeat (60) @(posedge clk_i);
    out_hold = 0;
    drain();

    for (int ph = 0; ph < 16; ph++) begin
      ax = near_coord(); ay = near_coord();
      set_shape(shape_e'(ph % 4), ax, ay, near_coord(), near_coord(),
                small_ext(), small_ext());
      if (ph % 4 == SHAPE_LINE && $urandom_range(0, 2) == 0)
        write_reg(REG_END_X, 16'(ax));
      for (int k = 0; k < 25; k++) begin
        // half the cells aimed around the anchor to find outline cells
        if ($urandom_range(0, 1)) begin
          x = ax + $urandom_range(0, 40) - 20;
          y = ay + $urandom_range(0, 40) - 20;
          if (x < 0 || x > 63) x = $urandom_range(0, 63);
          if (y < 0 || y > 63) y = $urandom_range(0, 63);
          if (ph % 4 == SHAPE_CIRCLE) push_cell(x, y); else push_cell(y, x);
        end else push_cell($urandom_range(0, 63), $urandom_range(0, 63));
      end
      drain();
      // write past the last register index, must be ignored
      if (ph == 5) write_reg(3'd7, 16'hffff);
    end

    drain();
    $display("covered %0d cells over all four shapes, %0d results, %0d hits",
             n_cells, n_words, n_hits);
    $display("register extremes, partly off-board shapes and output back-pressure");
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
